### hdl/dip_pkg.sv
package dip_pkg;

  localparam int CharWidth  = 8;
  localparam int ValueWidth = 32;
  // Digit accumulation: 32-bit magnitude times ten plus a digit fits in 36 bits.
  localparam int AccWidth   = ValueWidth + 4;

  localparam logic [CharWidth-1:0] CH_NUL   = 8'h00;
  localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;
  localparam logic [CharWidth-1:0] CH_TAB   = 8'h09;
  localparam logic [CharWidth-1:0] CH_LF    = 8'h0A;
  localparam logic [CharWidth-1:0] CH_VT    = 8'h0B;
  localparam logic [CharWidth-1:0] CH_FF    = 8'h0C;
  localparam logic [CharWidth-1:0] CH_CR    = 8'h0D;
  localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;

  localparam logic [ValueWidth-1:0] MaxPositive = 32'h7FFF_FFFF;
  localparam logic [ValueWidth-1:0] MaxNegative = 32'h8000_0000;
  localparam logic [ValueWidth-1:0] Saturated   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_REJECT = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic                  negative;
    logic [ValueWidth-1:0] magnitude;
    logic                  too_large;
  } parse_state_t;

  typedef struct packed {
    logic                  well_formed;
    logic [ValueWidth-1:0] value;
  } parse_result_t;

  localparam parse_state_t StateReset = '{
    phase:     PH_SKIP,
    negative:  1'b0,
    magnitude: '0,
    too_large: 1'b0
  };

  function automatic logic is_blank(input logic [CharWidth-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [CharWidth-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

### hdl/dip_step.sv
module dip_step (
  input  dip_pkg::parse_state_t            cur,
  input  logic [dip_pkg::CharWidth-1:0]    char_byte,
  output dip_pkg::parse_state_t            nxt,
  output dip_pkg::parse_result_t           result
);
  import dip_pkg::*;

  logic [AccWidth-1:0]   acc;
  logic                  acc_over;
  parse_state_t          digit_state;

  // Multiply by ten as (m << 3) + (m << 1), then add the digit.
  always_comb begin
    acc = {1'b0, cur.magnitude, 3'b0} + {3'b0, cur.magnitude, 1'b0} +
          {{(AccWidth-4){1'b0}}, char_byte[3:0]};
    acc_over = cur.too_large || (acc[AccWidth-1:ValueWidth] != 4'b0);
    digit_state           = cur;
    digit_state.phase     = PH_DIGITS;
    digit_state.too_large = acc_over;
    digit_state.magnitude = acc_over ? Saturated : acc[ValueWidth-1:0];
  end

  // Next state.
  always_comb begin
    nxt = cur;
    if (char_byte == CH_NUL) begin
      nxt = StateReset;
    end else begin
      unique case (cur.phase)
        PH_SKIP: begin
          if (is_blank(char_byte)) begin
            nxt = cur;
          end else if ((char_byte == CH_PLUS) || (char_byte == CH_MINUS)) begin
            nxt.negative = (char_byte == CH_MINUS);
            nxt.phase    = PH_SIGN;
          end else if (is_digit(char_byte)) begin
            nxt = digit_state;
          end else begin
            nxt.phase = PH_REJECT;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit(char_byte)) begin
            nxt = digit_state;
          end else begin
            nxt.phase = PH_REJECT;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  // Result, meaningful only when the word is the terminating zero byte.
  always_comb begin
    result.well_formed = 1'b0;
    result.value       = '0;
    if ((cur.phase == PH_DIGITS) && !cur.too_large) begin
      if (cur.negative) begin
        if (cur.magnitude <= MaxNegative) begin
          result.well_formed = 1'b1;
          result.value       = '0 - cur.magnitude;
        end
      end else if (cur.magnitude <= MaxPositive) begin
        result.well_formed = 1'b1;
        result.value       = cur.magnitude;
      end
    end
  end

endmodule

### hdl/decimal_int32_parser.sv
// A word accepted on s_axis passes the input register, then the parse step feeding
// the result register that drives m_axis. Throughput: one character per cycle,
// but a zero byte stalls while a result waits; the multiply by ten is shift-add in
// the step logic, and the result register lets other characters flow meanwhile.
// Reset clears the parse state and both valid flags; no result is pending.
module decimal_int32_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic        m_axis_tuser    // [0] well_formed
);
  import dip_pkg::*;

  logic                 in_valid;
  logic [CharWidth-1:0] in_byte;
  parse_state_t         st;
  parse_state_t         st_next;
  parse_result_t        step_result;
  parse_result_t        res;
  logic                 res_valid;
  logic                 in_is_end;
  logic                 advance;

  dip_step u_step (
    .cur       (st),
    .char_byte (in_byte),
    .nxt       (st_next),
    .result    (step_result)
  );

  assign in_is_end = (in_byte == CH_NUL);
  // A zero byte may only leave the input register when the result register is free.
  assign advance = in_valid && (!in_is_end || !res_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StateReset;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_is_end) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_is_end) begin
      res <= step_result;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = res.value;
  assign m_axis_tuser  = res.well_formed;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dip_pkg::*;

  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] char_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] value
  logic        m_axis_tuser;         // [0] well_formed

  // Parser state as the block should hold it.
  phase_t          cur_phase     = PH_SKIP;
  logic            cur_negative  = 1'b0;
  logic [31:0]     cur_magnitude = '0;
  logic            cur_too_large = 1'b0;

  parse_result_t   expected_results[$];
  int              chars_accepted    = 0;
  int              results_predicted = 0;
  int              error_count       = 0;
  int              idle_cycles       = 0;
  int              sender_idle_pct   = 0;
  int              receiver_idle_pct = 0;

  decimal_int32_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch in %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  // Advances the expected parser state by one character and queues a result
  // when the character is the terminating zero byte.
  task automatic parse_char(input logic [7:0] c);
    logic [35:0]   next_mag;
    logic          is_dig;
    parse_result_t res;
    chars_accepted++;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_NUL) begin
      res.well_formed = 1'b0;
      res.value       = '0;
      if (cur_phase == PH_DIGITS && !cur_too_large) begin
        if (cur_negative && cur_magnitude <= MaxNegative) begin
          res.well_formed = 1'b1;
          res.value       = 32'd0 - cur_magnitude;
        end else if (!cur_negative && cur_magnitude <= MaxPositive) begin
          res.well_formed = 1'b1;
          res.value       = cur_magnitude;
        end
      end
      expected_results.push_back(res);
      results_predicted++;
      cur_phase     = PH_SKIP;
      cur_negative  = 1'b0;
      cur_magnitude = '0;
      cur_too_large = 1'b0;
    end else if (cur_phase == PH_REJECT) begin
      // Everything up to the terminator is ignored once the string is rejected.
    end else if (is_dig) begin
      next_mag = 36'(cur_magnitude) * 36'd10 + 36'(c - CH_ZERO);
      if (cur_too_large || next_mag > 36'(Saturated)) begin
        cur_too_large = 1'b1;
        cur_magnitude = Saturated;
      end else begin
        cur_magnitude = next_mag[31:0];
      end
      cur_phase = PH_DIGITS;
    end else if (cur_phase == PH_SKIP &&
                 c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
      // Leading whitespace keeps the parser where it is.
    end else if (cur_phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
      cur_negative = (c == CH_MINUS);
      cur_phase    = PH_SIGN;
    end else begin
      cur_phase = PH_REJECT;
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    parse_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_string(input string s);
    send_text(s);
    send_char(CH_NUL);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_stray();
    case ($urandom_range(0, 3))
      0: return pick_blank();
      1: return ($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Mostly well-formed numbers with random content; some get a stray
  // character spliced in, and a few are plain noise.
  task automatic send_random_string();
    int              kind;
    int              bad_at;
    longint unsigned mag;
    string           digits;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      repeat ($urandom_range(0, 6)) send_char(8'($urandom_range(1, 255)));
      send_char(CH_NUL);
      return;
    end
    repeat ($urandom_range(0, 3)) send_char(pick_blank());
    case ($urandom_range(0, 3))
      0: send_char(CH_PLUS);
      1: send_char(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: mag = 64'($urandom_range(0, 9));
      1: mag = 64'($urandom_range(0, 999));
      2: mag = 64'($urandom);
      3: mag = 64'd2147483640 + 64'($urandom_range(0, 16));
      4: mag = 64'd4294967290 + 64'($urandom_range(0, 12));
      default: mag = {32'($urandom), 32'($urandom)} % 64'd1000000000000;
    endcase
    digits = $sformatf("%0d", mag);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) digits = {"0", digits};
    end
    bad_at = (kind >= 6) ? int'($urandom_range(0, digits.len())) : -1;
    for (int i = 0; i < digits.len(); i++) begin
      if (i == bad_at) send_char(pick_stray());
      send_char(digits[i]);
    end
    if (bad_at == digits.len()) send_char(pick_stray());
    send_char(CH_NUL);
  endtask

  task automatic test_range_limits();
    send_string("0");
    send_string("2147483647");
    send_string("-2147483648");
    send_string("2147483648");
    send_string("-2147483649");
    send_string("4294967295");
    send_string("4294967296");
    send_string("99999999999999");
    send_string("-0");
    send_string("000000000042");
  endtask

  task automatic test_whitespace_and_signs();
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(CH_LF);
    send_char(CH_VT);
    send_char(CH_FF);
    send_char(CH_CR);
    send_string("+17");
    send_char(CH_NUL);
    send_char(CH_TAB);
    send_char(CH_SPACE);
    send_char(CH_NUL);
    send_string("-");
    send_string("+");
    send_string("+-5");
    send_string("--5");
    send_string("- 5");
    send_string("12 ");
  endtask

  task automatic test_stray_characters();
    send_string("12a34");
    send_char(8'hFF);
    send_string("7");
    send_string("x123");
    send_string("1-2");
    send_string("9:");
    send_string("/5");
  endtask

  task automatic test_random_strings(input int send_idle, input int recv_idle,
                                     input int char_target);
    int chars_start;
    int results_start;
    sender_idle_pct   = send_idle;
    receiver_idle_pct = recv_idle;
    chars_start       = chars_accepted;
    results_start     = results_predicted;
    while (chars_accepted - chars_start < char_target ||
           results_predicted - results_start < 20)
      send_random_string();
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", '0, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.well_formed)
          report_mismatch("well_formed", 32'(want.well_formed), 32'(m_axis_tuser));
        if (m_axis_tdata !== want.value)
          report_mismatch("value", want.value, m_axis_tdata);
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct   = 38;
    receiver_idle_pct = 58;
    test_range_limits();
    test_whitespace_and_signs();
    test_stray_characters();
    test_random_strings(38, 58, 110);
    test_random_strings(58, 38, 110);
    test_random_strings(0, 0, 110);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
